>>> rtl/bfpra_pkg.sv
// Shared types and constants of the best-fit page region allocator.
package bfpra_pkg;

	localparam int PAGE_BITS    = 36;
	localparam int COUNT_BITS   = 37;
	localparam int STAMP_BITS   = 32;
	localparam int MAX_REGIONS  = 64;
	localparam int CFG_IDX_BITS = 1;

	typedef enum logic [1:0] {
		REQ_ALLOC    = 2'd0,
		REQ_ALLOC_AT = 2'd1,
		REQ_FREE     = 2'd2,
		REQ_INIT     = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_NOT_FREE = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ZONE_BEGIN = 1'd0,
		CFG_ZONE_END   = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [PAGE_BITS-1:0]  page_number;
		logic [COUNT_BITS-1:0] num_pages;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [PAGE_BITS-1:0] result_page;
		logic [6:0]           free_entries;
	} rsp_t;

endpackage

>>> rtl/best_fit_page_region_allocator_unit.sv
// Top level of the best-fit page region allocator: sequencer, scan pipeline and region table.
//
// Usage: requests enter on req/req_valid/req_ready and each produces exactly one
// response on rsp/rsp_valid/rsp_ready. Request kinds are alloc (best fit), alloc at a
// given page, free a range, and init, which empties the table and loads the zone set
// through the configuration port (cfg_we, cfg_index, cfg_wdata; write only when idle).
// Each alloc, alloc-at or free request scans the whole table once through the single
// read port of the region memory, one entry per cycle, feeding a shared size/age
// compare unit. An alloc-at that splits a range in two goes through the extra write
// state S_WRITE2, since the memory has one write port; init skips the scan.
// One request is in flight at a time; req_ready is high only between requests.
// A finished response sits in an output register, so the next request may be taken
// while the receiver stalls; the block then waits before loading a new response.
// Reset empties the table (valid bits in flip-flops), clears the insertion counter
// and the zone registers; no clearing pass over the memory is needed.
module best_fit_page_region_allocator_unit #(
	parameter int MAX_REGIONS = bfpra_pkg::MAX_REGIONS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  bfpra_pkg::req_t                       req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output bfpra_pkg::rsp_t                       rsp,
	input  logic                                  cfg_we,
	input  logic [bfpra_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bfpra_pkg::COUNT_BITS-1:0]      cfg_wdata
);

	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int PB    = bfpra_pkg::PAGE_BITS;
	localparam int CB    = bfpra_pkg::COUNT_BITS;
	localparam int SB    = bfpra_pkg::STAMP_BITS;
	localparam logic [CB:0] PAGE_LIMIT = (CB+1)'(1) << PB;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_WRITE2 = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [PB-1:0] zone_begin_q;
	logic [CB-1:0] zone_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_begin_q <= '0;
			zone_end_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfpra_pkg::CFG_ZONE_BEGIN: zone_begin_q <= cfg_wdata[PB-1:0];
				bfpra_pkg::CFG_ZONE_END: begin
					if ({1'b0, cfg_wdata} > PAGE_LIMIT)
						zone_end_q <= PAGE_LIMIT[CB-1:0];
					else
						zone_end_q <= cfg_wdata;
				end
				default: ;
			endcase
		end
	end

	logic rsp_load, zone_ok;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid || rsp_ready);
	assign zone_ok  = CB'(zone_begin_q) < zone_end_q;

	// Latched request.
	logic [1:0]    type_q;
	logic [PB-1:0] page_q;
	logic [CB-1:0] cnt_q;

	// Table state.
	logic [MAX_REGIONS-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [SB-1:0]          ctr_q;

	logic [PB-1:0] mem_begin [MAX_REGIONS];
	logic [CB-1:0] mem_end   [MAX_REGIONS];
	logic [SB-1:0] mem_stamp [MAX_REGIONS];

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [PB-1:0]    wr_begin;
	logic [CB-1:0]    wr_end;
	logic [SB-1:0]    wr_stamp;
	logic [IDX_W-1:0] rd_addr;

	// Scan pipeline.
	logic [IDX_W:0]   issue_q;
	logic             v_s1, ev_s1, v_s2, pre_ok_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [PB-1:0]    begin_s1, begin_s2;
	logic [CB-1:0]    end_s1, end_s2, size_s2;
	logic [SB-1:0]    stamp_s1, age_s2;

	// Best candidate and lowest free slot.
	logic             best_found_q, free_found_q;
	logic [IDX_W-1:0] best_idx_q, free_idx_q;
	logic [PB-1:0]    best_begin_q;
	logic [CB-1:0]    best_end_q, best_size_q;
	logic [SB-1:0]    best_age_q;

	// Decision results.
	logic [1:0]    status_q;
	logic [PB-1:0] result_q;

	logic issuing, scan_end;
	assign issuing  = (state_q == S_SCAN) && (issue_q < (IDX_W+1)'(MAX_REGIONS));
	assign scan_end = (state_q == S_SCAN) && !issuing && !v_s1 && !v_s2;
	assign rd_addr  = issue_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_begin[wr_addr] <= wr_begin;
			mem_end[wr_addr]   <= wr_end;
			mem_stamp[wr_addr] <= wr_stamp;
		end
		begin_s1 <= mem_begin[rd_addr];
		end_s1   <= mem_end[rd_addr];
		stamp_s1 <= mem_stamp[rd_addr];
	end

	// Stage two: size, age and the containment check.
	logic hold_ok;
	assign hold_ok = (type_q != bfpra_pkg::REQ_ALLOC_AT) ||
		((page_q >= begin_s1) && ({1'b0, page_q} < end_s1));

	always_ff @(posedge clk) begin
		size_s2   <= end_s1 - CB'(begin_s1);
		age_s2    <= ctr_q - stamp_s1;
		pre_ok_s2 <= ev_s1 && (end_s1 > CB'(begin_s1)) && hold_ok;
		begin_s2  <= begin_s1;
		end_s2    <= end_s1;
		idx_s2    <= idx_s1;
		idx_s1    <= rd_addr;
	end

	// Stage three: compare against the best so far.
	logic better;
	assign better = pre_ok_s2 && (size_s2 >= cnt_q) && (!best_found_q ||
		(size_s2 < best_size_q) || ((size_s2 == best_size_q) && (age_s2 > best_age_q)));

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			best_found_q <= 1'b0;
		end else if (v_s2 && better) begin
			best_found_q <= 1'b1;
			best_idx_q   <= idx_s2;
			best_begin_q <= begin_s2;
			best_end_q   <= end_s2;
			best_size_q  <= size_s2;
			best_age_q   <= age_s2;
		end
	end

	// Decision arithmetic.
	logic [CB:0] run_end;   // page + count
	logic [CB:0] new_begin; // best begin + count
	logic        has_left, has_right;
	assign run_end   = (CB+1)'(page_q) + (CB+1)'(cnt_q);
	assign new_begin = (CB+1)'(best_begin_q) + (CB+1)'(cnt_q);
	assign has_left  = best_begin_q < page_q;
	assign has_right = run_end < (CB+1)'(best_end_q);

	logic cnt_zero;
	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = best_idx_q;
		wr_begin = best_begin_q;
		wr_end   = best_end_q;
		wr_stamp = ctr_q;
		if (state_q == S_DECIDE) begin
			unique case (type_q)
				bfpra_pkg::REQ_ALLOC: begin
					if (!cnt_zero && best_found_q && (new_begin < (CB+1)'(best_end_q))) begin
						wr_en    = 1'b1;
						wr_begin = new_begin[PB-1:0];
					end
				end
				bfpra_pkg::REQ_ALLOC_AT: begin
					if (!cnt_zero && best_found_q && (run_end <= (CB+1)'(best_end_q)) &&
						!(has_left && has_right && !free_found_q)) begin
						if (has_left) begin
							wr_en  = 1'b1;
							wr_end = CB'(page_q);
						end else if (has_right) begin
							wr_en    = 1'b1;
							wr_begin = run_end[PB-1:0];
						end
					end
				end
				bfpra_pkg::REQ_FREE: begin
					wr_addr  = free_idx_q;
					wr_begin = page_q;
					wr_end   = (run_end > PAGE_LIMIT) ? PAGE_LIMIT[CB-1:0] : run_end[CB-1:0];
					wr_en    = !cnt_zero && free_found_q;
				end
				bfpra_pkg::REQ_INIT: begin
					// The zone entry is the first insertion after the counter restarts.
					wr_addr  = '0;
					wr_begin = zone_begin_q;
					wr_end   = zone_end_q;
					wr_stamp = '0;
					wr_en    = zone_ok;
				end
				default: ;
			endcase
		end else if (state_q == S_WRITE2) begin
			wr_en    = 1'b1;
			wr_addr  = free_idx_q;
			wr_begin = run_end[PB-1:0];
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			count_q      <= '0;
			ctr_q        <= '0;
			issue_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			ev_s1        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			rsp_valid    <= 1'b0;
			status_q     <= '0;
			result_q     <= '0;
			type_q       <= '0;
			page_q       <= '0;
			cnt_q        <= '0;
		end else begin
			v_s1  <= issuing;
			ev_s1 <= issuing && valid_q[rd_addr];
			v_s2  <= v_s1;
			if (rsp_load)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
			if ((state_q == S_DECIDE) && (type_q == bfpra_pkg::REQ_INIT))
				ctr_q <= SB'(zone_ok);
			else if (wr_en)
				ctr_q <= ctr_q + SB'(1);

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						type_q       <= req.req_type;
						page_q       <= req.page_number;
						cnt_q        <= req.num_pages;
						issue_q      <= '0;
						free_found_q <= 1'b0;
						state_q      <= (req.req_type == bfpra_pkg::REQ_INIT) ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + (IDX_W+1)'(1);
						if (!free_found_q && !valid_q[rd_addr]) begin
							free_found_q <= 1'b1;
							free_idx_q   <= rd_addr;
						end
					end
					if (scan_end)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					status_q <= bfpra_pkg::ST_OK;
					result_q <= '0;
					state_q  <= S_DONE;
					unique case (type_q)
						bfpra_pkg::REQ_ALLOC: begin
							if (cnt_zero || !best_found_q) begin
								status_q <= bfpra_pkg::ST_NO_FIT;
							end else begin
								result_q <= best_begin_q;
								if (!(new_begin < (CB+1)'(best_end_q))) begin
									valid_q[best_idx_q] <= 1'b0;
									count_q <= count_q - CNT_W'(1);
								end
							end
						end
						bfpra_pkg::REQ_ALLOC_AT: begin
							if (cnt_zero || !best_found_q || (run_end > (CB+1)'(best_end_q))) begin
								status_q <= bfpra_pkg::ST_NOT_FREE;
							end else if (has_left && has_right && !free_found_q) begin
								status_q <= bfpra_pkg::ST_FULL;
							end else begin
								result_q <= page_q;
								if (has_left && has_right) begin
									state_q <= S_WRITE2;
								end else if (!has_left && !has_right) begin
									valid_q[best_idx_q] <= 1'b0;
									count_q <= count_q - CNT_W'(1);
								end
							end
						end
						bfpra_pkg::REQ_FREE: begin
							if (!cnt_zero) begin
								if (!free_found_q) begin
									status_q <= bfpra_pkg::ST_FULL;
								end else begin
									valid_q[free_idx_q] <= 1'b1;
									count_q <= count_q + CNT_W'(1);
								end
							end
						end
						bfpra_pkg::REQ_INIT: begin
							valid_q <= zone_ok ? MAX_REGIONS'(1) : '0;
							count_q <= zone_ok ? CNT_W'(1) : '0;
						end
						default: ;
					endcase
				end
				S_WRITE2: begin
					valid_q[free_idx_q] <= 1'b1;
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.status       <= status_q;
			rsp.result_page  <= result_q;
			rsp.free_entries <= 7'(count_q);
		end
	end

	assign req_ready = (state_q == S_IDLE);

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (32'(count_q) == 32'($countones(valid_q))))
		else $error("entry count disagrees with valid bits");
	a_free_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DECIDE) && free_found_q) |-> !valid_q[free_idx_q])
		else $error("chosen free slot is occupied");
	a_best_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DECIDE) && best_found_q && (type_q != bfpra_pkg::REQ_INIT))
		|-> valid_q[best_idx_q])
		else $error("best-fit candidate is not a valid entry");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

endmodule
